[rtl/smw_pkg.sv]
// ----------------------------------------------------------------------------
// smw_pkg
// Shared widths, register indexes and reset values of the mesh warp.
// ----------------------------------------------------------------------------
package smw_pkg;

    localparam int GRID_W     = 10;   // grid_col / grid_row
    localparam int IMG_W      = 14;   // image_width / image_height
    localparam int CNT_W      = 11;   // mesh_columns / mesh_rows
    localparam int FOC_W      = 20;   // focal_length
    localparam int DIAG_W     = 21;   // diagonal
    localparam int OUT_W      = 24;   // map_x / map_y
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_MESH_COLUMNS = 3'd2;
    localparam t_cfg_idx CFG_MESH_ROWS    = 3'd3;
    localparam t_cfg_idx CFG_FOCAL_LENGTH = 3'd4;
    localparam t_cfg_idx CFG_DIAGONAL     = 3'd5;

    localparam logic [IMG_W-1:0]  RST_IMAGE_WIDTH  = 14'd1920;
    localparam logic [IMG_W-1:0]  RST_IMAGE_HEIGHT = 14'd1080;
    localparam logic [CNT_W-1:0]  RST_MESH_COLUMNS = 11'd104;
    localparam logic [CNT_W-1:0]  RST_MESH_ROWS    = 11'd104;
    localparam logic [FOC_W-1:0]  RST_FOCAL_LENGTH = 20'd25600;
    localparam logic [DIAG_W-1:0] RST_DIAGONAL     = 21'd35248;

endpackage

[rtl/smw_div_pipe.sv]
// ----------------------------------------------------------------------------
// smw_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees num >> QW < den.
// ----------------------------------------------------------------------------
module smw_div_pipe #(
    parameter int QW = 29,
    parameter int DW = 11,
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [QW+DW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [QW-1:0]    o_quot,
    output logic [SW-1:0]    o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [DW-1:0] r_den  [QW];
    logic          r_val  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [DW-1:0] den_in;
        logic          val_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_low;

        if (k == 0) begin : g_first
            assign rem_in  = i_num[QW+DW-1:QW];
            assign low_in  = i_num[QW-1:0];
            assign den_in  = i_den;
            assign val_in  = i_valid;
            assign side_in = i_side;
        end else begin : g_rest
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign den_in  = r_den[k-1];
            assign val_in  = r_val[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            trial = {rem_in, low_in[QW-1]};
            ge    = (trial >= {1'b0, den_in});
            n_rem = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
            n_low = {low_in[QW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else if (i_en) begin
                r_val[k] <= val_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= n_low;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_val[QW-1];
    assign o_quot  = r_low[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

[rtl/smw_isqrt_pipe.sv]
// ----------------------------------------------------------------------------
// smw_isqrt_pipe
// Pipelined floor integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module smw_isqrt_pipe #(
    parameter int IW = 60,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [IW-1:0]   i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [IW/2-1:0] o_root,
    output logic [SW-1:0]   o_side
);

    localparam int RW = IW / 2;
    localparam int EW = RW + 3;

    logic [EW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [IW-1:0] r_rad  [RW];
    logic          r_val  [RW];
    logic [SW-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [EW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [IW-1:0] rad_in;
        logic          val_in;
        logic [SW-1:0] side_in;
        logic [EW-1:0] shifted;
        logic [EW-1:0] trial;
        logic          ge;
        logic [EW-1:0] n_rem;
        logic [RW-1:0] n_root;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign val_in  = i_valid;
            assign side_in = i_side;
        end else begin : g_rest
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign val_in  = r_val[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            shifted = {rem_in[EW-3:0], rad_in[IW-1:IW-2]};
            trial   = {1'b0, root_in, 2'b01};
            ge      = (shifted >= trial);
            n_rem   = ge ? (shifted - trial) : shifted;
            n_root  = {root_in[RW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else if (i_en) begin
                r_val[k] <= val_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= {rad_in[IW-3:0], 2'b00};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_val[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

[rtl/stereographic_mesh_warp.sv]
// ----------------------------------------------------------------------------
// stereographic_mesh_warp
// Maps one warp mesh point to its stereographic source coordinate.
// ----------------------------------------------------------------------------
// Use: the slave stream takes one mesh point a beat (grid_col, grid_row); the
// master stream returns one beat per point: map_x, map_y in 1/2^OUT_FRAC_BITS
// pixel and a saturation flag on tuser. The user must write registers through
// the plain write port only while no beat is in flight; the block itself
// does not enforce it. Throughput: one beat per cycle while the shared
// enable is high. The pipeline holds the two divider chains (29 and
// OUT_FRAC_BITS+26 stages) and the 30-stage square root.
// The constant r0 = 2f + isqrt(4f^2 + d^2) runs in its own pipeline
// straight off the registers; it settles long before a beat needs it.
// Reset: valid bits clear, registers return to their defaults, no beat out.
// Stall: the whole pipeline shares one enable. It keeps moving while the
// output register is empty, being taken, or while the last stage holds a
// bubble, so new points are taken while a result waits. Nothing is lost.
// ----------------------------------------------------------------------------
module stereographic_mesh_warp
    import smw_pkg::*;
#(
    parameter int MESH_MARGIN   = 4,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // mesh points
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // grid_col[9:0], grid_row[19:10], zero pad
    // source coordinates
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // map_x[23:0], map_y[47:24]
    output logic                   o_m_tuser    // saturated
);

    localparam int F       = OUT_FRAC_BITS;
    localparam int PROD_W  = IMG_W + GRID_W;       // size * |g - margin|
    localparam int NUMC_W  = PROD_W + 5;           // 16x product + half divisor
    localparam int PW      = NUMC_W + 1;           // signed centred position
    localparam int AW      = NUMC_W;               // |p|
    localparam int SQ_W    = 2 * AW;
    localparam int FF_W    = 2 * FOC_W;
    localparam int RAD_W   = SQ_W + 2;
    localparam int RT_W    = RAD_W / 2;
    localparam int DEN2_W  = RT_W + 1;
    localparam int R0RAD_W = 2 * DIAG_W + 2;
    localparam int R0RT_W  = R0RAD_W / 2;
    localparam int R0_W    = R0RT_W + 1;
    localparam int A_W     = AW + R0_W;
    localparam int NO_W    = A_W + F + 2;
    localparam int DO_W    = DEN2_W + 5;
    localparam int QO_W    = F + 26;               // enough to saturate
    localparam int SO_W    = QO_W + 2;
    localparam int SIDE_W  = 2 * AW + 2;

    localparam logic signed [SO_W-1:0] LIM_HI = SO_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [SO_W-1:0] LIM_LO = -LIM_HI - SO_W'(1);

    // ---------------- configuration registers ----------------
    logic [IMG_W-1:0]  r_img_w, r_img_h;
    logic [CNT_W-1:0]  r_cols, r_rows;
    logic [FOC_W-1:0]  r_focal;
    logic [DIAG_W-1:0] r_diag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RST_IMAGE_WIDTH;
            r_img_h <= RST_IMAGE_HEIGHT;
            r_cols  <= RST_MESH_COLUMNS;
            r_rows  <= RST_MESH_ROWS;
            r_focal <= RST_FOCAL_LENGTH;
            r_diag  <= RST_DIAGONAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[IMG_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[IMG_W-1:0];
                CFG_MESH_COLUMNS: r_cols  <= i_cfg_data[CNT_W-1:0];
                CFG_MESH_ROWS:    r_rows  <= i_cfg_data[CNT_W-1:0];
                CFG_FOCAL_LENGTH: r_focal <= i_cfg_data[FOC_W-1:0];
                CFG_DIAGONAL:     r_diag  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // mesh pitch divisors, clamped to 1 for a mesh no wider than its margins
    logic signed [CNT_W:0] den_x_s, den_y_s;
    logic [CNT_W-1:0]      den_x, den_y;

    always_comb begin
        den_x_s = $signed({1'b0, r_cols}) - $signed((CNT_W+1)'(2 * MESH_MARGIN));
        den_y_s = $signed({1'b0, r_rows}) - $signed((CNT_W+1)'(2 * MESH_MARGIN));
        den_x   = (den_x_s < $signed((CNT_W+1)'(1))) ? CNT_W'(1) : den_x_s[CNT_W-1:0];
        den_y   = (den_y_s < $signed((CNT_W+1)'(1))) ? CNT_W'(1) : den_y_s[CNT_W-1:0];
    end

    // ---------------- r0 = 2f + isqrt(4f^2 + d^2), free running ----------------
    logic [R0RAD_W-1:0] r_r0_rad;
    logic [R0RT_W-1:0]  r0_root;
    logic [R0_W-1:0]    r_r0;

    always_ff @(posedge i_clk) begin
        r_r0_rad <= (R0RAD_W'(r_focal) * R0RAD_W'(r_focal) << 2)
                  + R0RAD_W'(r_diag) * R0RAD_W'(r_diag);
        r_r0     <= R0_W'(r0_root) + R0_W'({r_focal, 1'b0});
    end

    smw_isqrt_pipe #(.IW(R0RAD_W), .SW(1)) u_r0_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (1'b1),
        .i_valid (1'b1),
        .i_rad   (r_r0_rad),
        .i_side  (1'b0),
        .o_valid (),
        .o_root  (r0_root),
        .o_side  ()
    );

    // ---------------- shared pipeline enable ----------------
    logic r_s10_v, r_out_v, en;

    assign en         = !r_s10_v || !r_out_v || i_m_tready;
    assign o_s_tready = en;

    // ---------------- stage 1: offset from margin, size product ----------------
    logic signed [GRID_W:0] n_dx, n_dy;
    logic [GRID_W-1:0]      n_mx, n_my;
    logic                   r_s1_v, r_s1_sx, r_s1_sy;
    logic [PROD_W-1:0]      r_s1_px, r_s1_py;

    always_comb begin
        n_dx = $signed({1'b0, i_s_tdata[GRID_W-1:0]}) - $signed((GRID_W+1)'(MESH_MARGIN));
        n_dy = $signed({1'b0, i_s_tdata[2*GRID_W-1:GRID_W]})
             - $signed((GRID_W+1)'(MESH_MARGIN));
        n_mx = GRID_W'(n_dx[GRID_W] ? -n_dx : n_dx);
        n_my = GRID_W'(n_dy[GRID_W] ? -n_dy : n_dy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sx <= n_dx[GRID_W];
            r_s1_sy <= n_dy[GRID_W];
            r_s1_px <= PROD_W'(r_img_w) * PROD_W'(n_mx);
            r_s1_py <= PROD_W'(r_img_h) * PROD_W'(n_my);
        end
    end

    // ---------------- stage 2: 16x product plus half divisor ----------------
    logic              r_s2_v, r_s2_sx, r_s2_sy;
    logic [NUMC_W-1:0] r_s2_nx, r_s2_ny;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sx <= r_s1_sx;
            r_s2_sy <= r_s1_sy;
            r_s2_nx <= (NUMC_W'(r_s1_px) << 4) + NUMC_W'(den_x >> 1);
            r_s2_ny <= (NUMC_W'(r_s1_py) << 4) + NUMC_W'(den_y >> 1);
        end
    end

    // ---------------- grid dividers ----------------
    logic              cx_v, cy_v, cx_s, cy_s;
    logic [NUMC_W-1:0] cx_q, cy_q;

    smw_div_pipe #(.QW(NUMC_W), .DW(CNT_W), .SW(1)) u_div_cx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (r_s2_v), .i_num ({CNT_W'(0), r_s2_nx}), .i_den (den_x),
        .i_side (r_s2_sx), .o_valid (cx_v), .o_quot (cx_q), .o_side (cx_s)
    );

    smw_div_pipe #(.QW(NUMC_W), .DW(CNT_W), .SW(1)) u_div_cy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (r_s2_v), .i_num ({CNT_W'(0), r_s2_ny}), .i_den (den_y),
        .i_side (r_s2_sy), .o_valid (cy_v), .o_quot (cy_q), .o_side (cy_s)
    );

    // ---------------- stage 3: signed centred position p ----------------
    logic                 r_s3_v;
    logic signed [PW-1:0] r_s3_px, r_s3_py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_px <= (cx_s ? -$signed({1'b0, cx_q}) : $signed({1'b0, cx_q}))
                     - $signed(PW'({r_img_w, 3'b000}));
            r_s3_py <= (cy_s ? -$signed({1'b0, cy_q}) : $signed({1'b0, cy_q}))
                     - $signed(PW'({r_img_h, 3'b000}));
        end
    end

    // ---------------- stage 4: magnitude and sign ----------------
    logic          r_s4_v, r_s4_sx, r_s4_sy;
    logic [AW-1:0] r_s4_ax, r_s4_ay;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_sx <= r_s3_px[PW-1];
            r_s4_sy <= r_s3_py[PW-1];
            r_s4_ax <= AW'(r_s3_px[PW-1] ? -r_s3_px : r_s3_px);
            r_s4_ay <= AW'(r_s3_py[PW-1] ? -r_s3_py : r_s3_py);
        end
    end

    // ---------------- stage 5: squares ----------------
    logic            r_s5_v, r_s5_sx, r_s5_sy;
    logic [AW-1:0]   r_s5_ax, r_s5_ay;
    logic [SQ_W-1:0] r_s5_qx, r_s5_qy;
    logic [FF_W-1:0] r_s5_ff;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_sx <= r_s4_sx;
            r_s5_sy <= r_s4_sy;
            r_s5_ax <= r_s4_ax;
            r_s5_ay <= r_s4_ay;
            r_s5_qx <= SQ_W'(r_s4_ax) * SQ_W'(r_s4_ax);
            r_s5_qy <= SQ_W'(r_s4_ay) * SQ_W'(r_s4_ay);
            r_s5_ff <= FF_W'(r_focal) * FF_W'(r_focal);
        end
    end

    // ---------------- stage 6: f^2 + px^2 + py^2 ----------------
    logic             r_s6_v;
    logic [SIDE_W-1:0] r_s6_side;
    logic [RAD_W-1:0] r_s6_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_side <= {r_s5_ax, r_s5_ay, r_s5_sx, r_s5_sy};
            r_s6_rad  <= RAD_W'(r_s5_qx) + RAD_W'(r_s5_qy) + RAD_W'(r_s5_ff);
        end
    end

    logic              rt_v;
    logic [RT_W-1:0]   rt_root;
    logic [SIDE_W-1:0] rt_side;
    logic [AW-1:0]     rt_ax, rt_ay;
    logic              rt_sx, rt_sy;

    smw_isqrt_pipe #(.IW(RAD_W), .SW(SIDE_W)) u_rad_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s6_v),
        .i_rad   (r_s6_rad),
        .i_side  (r_s6_side),
        .o_valid (rt_v),
        .o_root  (rt_root),
        .o_side  (rt_side)
    );

    assign {rt_ax, rt_ay, rt_sx, rt_sy} = rt_side;

    // ---------------- stage 7: denominator, |p| * r0 ----------------
    logic              r_s7_v, r_s7_sx, r_s7_sy, r_s7_zx, r_s7_zy;
    logic [DEN2_W-1:0] r_s7_den;
    logic [A_W-1:0]    r_s7_ax, r_s7_ay;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_sx  <= rt_sx;
            r_s7_sy  <= rt_sy;
            r_s7_zx  <= (rt_ax == '0);
            r_s7_zy  <= (rt_ay == '0);
            r_s7_den <= DEN2_W'(rt_root) + DEN2_W'(r_focal);
            r_s7_ax  <= A_W'(rt_ax) * A_W'(r_r0);
            r_s7_ay  <= A_W'(rt_ay) * A_W'(r_r0);
        end
    end

    // ---------------- stage 8: rounding numerator and divisor ----------------
    // offset in half units = floor((a*2^(F+1) + 16*den) / (32*den))
    logic            r_s8_v, r_s8_sx, r_s8_sy, r_s8_zx, r_s8_zy;
    logic [NO_W-1:0] r_s8_nx, r_s8_ny;
    logic [DO_W-1:0] r_s8_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_sx <= r_s7_sx;
            r_s8_sy <= r_s7_sy;
            r_s8_zx <= r_s7_zx;
            r_s8_zy <= r_s7_zy;
            r_s8_nx <= (NO_W'(r_s7_ax) << (F + 1)) + NO_W'({r_s7_den, 4'b0000});
            r_s8_ny <= (NO_W'(r_s7_ay) << (F + 1)) + NO_W'({r_s7_den, 4'b0000});
            r_s8_d  <= {r_s7_den, 5'b00000};
        end
    end

    // quotient too big for the divider: far outside the output range anyway
    logic n_ovx, n_ovy;

    always_comb begin
        n_ovx = ((r_s8_nx >> QO_W) >= NO_W'(r_s8_d));
        n_ovy = ((r_s8_ny >> QO_W) >= NO_W'(r_s8_d));
    end

    logic            ox_v, oy_v;
    logic [QO_W-1:0] ox_q, oy_q;
    logic [2:0]      ox_side, oy_side;

    smw_div_pipe #(.QW(QO_W), .DW(DO_W), .SW(3)) u_div_ox (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (r_s8_v), .i_num ((QO_W+DO_W)'(r_s8_nx)), .i_den (r_s8_d),
        .i_side ({r_s8_sx, r_s8_zx, n_ovx}),
        .o_valid (ox_v), .o_quot (ox_q), .o_side (ox_side)
    );

    smw_div_pipe #(.QW(QO_W), .DW(DO_W), .SW(3)) u_div_oy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_valid (r_s8_v), .i_num ((QO_W+DO_W)'(r_s8_ny)), .i_den (r_s8_d),
        .i_side ({r_s8_sy, r_s8_zy, n_ovy}),
        .o_valid (oy_v), .o_quot (oy_q), .o_side (oy_side)
    );

    // ---------------- stage 10: centre + offset + 1 (half units) ----------------
    logic [QO_W-1:0]        n_vx, n_vy;
    logic signed [SO_W-1:0] n_ofx, n_ofy;
    logic signed [SO_W-1:0] r_s10_x, r_s10_y;

    always_comb begin
        n_vx  = ox_side[1] ? '0 : (ox_side[0] ? '1 : ox_q);
        n_vy  = oy_side[1] ? '0 : (oy_side[0] ? '1 : oy_q);
        n_ofx = ox_side[2] ? -$signed(SO_W'(n_vx)) : $signed(SO_W'(n_vx));
        n_ofy = oy_side[2] ? -$signed(SO_W'(n_vy)) : $signed(SO_W'(n_vy));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s10_x <= $signed(SO_W'(r_img_w) << F) + n_ofx + SO_W'(1);
            r_s10_y <= $signed(SO_W'(r_img_h) << F) + n_ofy + SO_W'(1);
        end
    end

    // ---------------- valid chain of the local stages ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_s6_v  <= 1'b0;
            r_s7_v  <= 1'b0;
            r_s8_v  <= 1'b0;
            r_s10_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_s_tvalid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= cx_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_s6_v  <= r_s5_v;
            r_s7_v  <= rt_v;
            r_s8_v  <= r_s7_v;
            r_s10_v <= ox_v;
        end
    end

    // ---------------- output register: halve (floor), clip ----------------
    logic signed [SO_W-1:0]  n_hx, n_hy;
    logic signed [OUT_W-1:0] n_mapx, n_mapy, r_out_x, r_out_y;
    logic                    n_sat, r_out_sat;

    always_comb begin
        n_hx  = r_s10_x >>> 1;
        n_hy  = r_s10_y >>> 1;
        n_sat = (n_hx > LIM_HI) || (n_hx < LIM_LO) || (n_hy > LIM_HI) || (n_hy < LIM_LO);
        if (n_hx > LIM_HI) begin
            n_mapx = LIM_HI[OUT_W-1:0];
        end else if (n_hx < LIM_LO) begin
            n_mapx = LIM_LO[OUT_W-1:0];
        end else begin
            n_mapx = n_hx[OUT_W-1:0];
        end
        if (n_hy > LIM_HI) begin
            n_mapy = LIM_HI[OUT_W-1:0];
        end else if (n_hy < LIM_LO) begin
            n_mapy = LIM_LO[OUT_W-1:0];
        end else begin
            n_mapy = n_hy[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en && r_s10_v) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s10_v) begin
            r_out_x   <= n_mapx;
            r_out_y   <= n_mapy;
            r_out_sat <= n_sat;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out_y, r_out_x};
    assign o_m_tuser  = r_out_sat;

    // ---------------- assertions ----------------
    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_s1_v)
        else $error("accepted beat did not enter stage 1");

    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s10_v && r_out_v && !i_m_tready) |-> !o_s_tready)
        else $error("pipeline moved while the output was blocked");

    a_lanes_aligned : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cx_v == cy_v) && (ox_v == oy_v))
        else $error("x and y divider lanes out of step");

    a_sat_at_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            ((r_out_x == LIM_HI[OUT_W-1:0]) || (r_out_x == LIM_LO[OUT_W-1:0]) ||
             (r_out_y == LIM_HI[OUT_W-1:0]) || (r_out_y == LIM_LO[OUT_W-1:0])))
        else $error("saturation flag without a clipped coordinate");

endmodule

[sim/smw_checker.sv]
// ----------------------------------------------------------------------------
// smw_checker
// Predicts and checks the mesh warp stream. It follows register writes,
// predicts each accepted point and compares each output beat in order.
// ----------------------------------------------------------------------------
module smw_checker
    import smw_pkg::*;
#(
    parameter int MESH_MARGIN   = 4,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tuser,
    output int                     o_errors,
    output int                     o_pending
);

    typedef struct packed {
        logic [OUT_W-1:0] map_x;
        logic [OUT_W-1:0] map_y;
        logic             saturated;
    } t_src_coord;

    localparam longint OUT_MAX = 64'sd8388607;
    localparam longint OUT_MIN = -64'sd8388608;

    logic [IMG_W-1:0]  img_w, img_h;
    logic [CNT_W-1:0]  cols, rows;
    logic [FOC_W-1:0]  focal;
    logic [DIAG_W-1:0] diag;

    t_src_coord coords_due[$];

    assign o_pending = coords_due.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, bit_w;
        r     = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= r + bit_w) begin
                v = v - (r + bit_w);
                r = (r >> 1) + bit_w;
            end else begin
                r = r >> 1;
            end
            bit_w >>= 2;
        end
        return r;
    endfunction

    // position relative to the centre, 1/16 pixel, half away from zero
    function automatic longint centre_offset(longint size, longint g, longint cnt);
        longint den, num, mag, q;
        den = cnt - 2 * MESH_MARGIN;
        if (den < 1) den = 1;
        num = 16 * size * (g - MESH_MARGIN);
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        if (num < 0) q = -q;
        return q - 8 * size;
    endfunction

    // p * r0 / (32 * den2) in half output units
    function automatic longint scaled_half(longint p, longint unsigned r0_2,
                                           longint unsigned den2);
        longint unsigned mag, d, a, q1, r1, v;
        mag = (p < 0) ? longint'(-p) : longint'(p);
        d   = 32 * den2;
        if (d == 0 || mag == 0) return 0;
        a  = mag * r0_2;
        q1 = a / d;
        r1 = a % d;
        v  = (q1 << (OUT_FRAC_BITS + 1)) + (((r1 << (OUT_FRAC_BITS + 1)) + d / 2) / d);
        return (p < 0) ? -longint'(v) : longint'(v);
    endfunction

    function automatic logic [OUT_W-1:0] clip_coord(longint size, longint off2,
                                                   inout logic sat);
        longint s, v;
        s = (size <<< OUT_FRAC_BITS) + off2 + 1;
        v = (s >= 0) ? s / 2 : -((-s + 1) / 2);
        if (v > OUT_MAX) begin
            v   = OUT_MAX;
            sat = 1'b1;
        end
        if (v < OUT_MIN) begin
            v   = OUT_MIN;
            sat = 1'b1;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic t_src_coord warp_point(logic [GRID_W-1:0] gc, logic [GRID_W-1:0] gr);
        t_src_coord      c;
        longint          px, py;
        longint unsigned f, d, ax, ay, r0_2, den2;
        logic            sat;
        f    = focal;
        d    = diag;
        px   = centre_offset(img_w, gc, cols);
        py   = centre_offset(img_h, gr, rows);
        ax   = (px < 0) ? -px : px;
        ay   = (py < 0) ? -py : py;
        r0_2 = 2 * f + int_sqrt(4 * f * f + d * d);
        den2 = f + int_sqrt(f * f + ax * ax + ay * ay);
        sat  = 1'b0;
        c.map_x     = clip_coord(img_w, scaled_half(px, r0_2, den2), sat);
        c.map_y     = clip_coord(img_h, scaled_half(py, r0_2, den2), sat);
        c.saturated = sat;
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t smw_checker: %s got %0h want %0h", $time, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_src_coord want;
        if (!i_rst_n) begin
            img_w = RST_IMAGE_WIDTH;
            img_h = RST_IMAGE_HEIGHT;
            cols  = RST_MESH_COLUMNS;
            rows  = RST_MESH_ROWS;
            focal = RST_FOCAL_LENGTH;
            diag  = RST_DIAGONAL;
            coords_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:  img_w = i_cfg_data[IMG_W-1:0];
                    CFG_IMAGE_HEIGHT: img_h = i_cfg_data[IMG_W-1:0];
                    CFG_MESH_COLUMNS: cols  = i_cfg_data[CNT_W-1:0];
                    CFG_MESH_ROWS:    rows  = i_cfg_data[CNT_W-1:0];
                    CFG_FOCAL_LENGTH: focal = i_cfg_data[FOC_W-1:0];
                    CFG_DIAGONAL:     diag  = i_cfg_data[DIAG_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                coords_due.push_back(warp_point(i_s_tdata[GRID_W-1:0],
                                                i_s_tdata[2*GRID_W-1:GRID_W]));
            if (i_m_tvalid && i_m_tready) begin
                if (coords_due.size() == 0) begin
                    report_mismatch("unexpected beat", i_m_tdata, 0);
                end else begin
                    want = coords_due.pop_front();
                    if (i_m_tdata[OUT_W-1:0] !== want.map_x)
                        report_mismatch("map_x", i_m_tdata[OUT_W-1:0], want.map_x);
                    if (i_m_tdata[2*OUT_W-1:OUT_W] !== want.map_y)
                        report_mismatch("map_y", i_m_tdata[2*OUT_W-1:OUT_W], want.map_y);
                    if (i_m_tuser !== want.saturated)
                        report_mismatch("saturated", i_m_tuser, want.saturated);
                end
            end
        end
    end

endmodule

[sim/tb_stereographic_mesh_warp.sv]
// ----------------------------------------------------------------------------
// tb_stereographic_mesh_warp
// Drives mesh points through the warp under a series of register settings,
// with idle and stall patterns on both streams and one long output hold-off.
// Prediction and comparison live in smw_checker.
// ----------------------------------------------------------------------------
module tb_stereographic_mesh_warp
    import smw_pkg::*;
;

    localparam t_cfg_idx CFG_SPARE = 3'd6;   // unmapped index, must be ignored
    localparam int       LIMIT     = 400000; // cycles before giving up
    localparam int       HOLD_LEN  = 400;    // long output hold-off
    localparam int       DRAIN     = 200;    // longer than the pipeline latency

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    t_cfg_idx               i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;

    int         errors, pending;
    int         cycles = 0;
    t_idle_mode idle_mode = IDLE_NONE;
    logic       hold_req = 1'b0;
    int         hold_left = 0;
    // mesh size in use, for picking points inside the mesh
    int         cur_cols = 104, cur_rows = 104;

    always #1 i_clk = ~i_clk;

    stereographic_mesh_warp i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_s_tvalid, .o_s_tready, .i_s_tdata,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser
    );

    smw_checker i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .o_errors(errors), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_stereographic_mesh_warp: errors");
            $finish;
        end
    end

    // receiver: random stalls per mode, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_left  <= HOLD_LEN;
            i_m_tready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECV: i_m_tready <= ($urandom_range(0, 99) >= 51);
                IDLE_BOTH: i_m_tready <= ($urandom_range(0, 99) >= 6);
                default:   i_m_tready <= 1'b1;
            endcase
        end
    end

    task automatic cfg_write(t_cfg_idx idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned c,
                                int unsigned r, int unsigned f, int unsigned d);
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
        cfg_write(CFG_MESH_COLUMNS, c);
        cfg_write(CFG_MESH_ROWS, r);
        cfg_write(CFG_FOCAL_LENGTH, f);
        cfg_write(CFG_DIAGONAL, d);
        cur_cols = c & 11'h7FF;
        cur_rows = r & 11'h7FF;
    endtask

    // one beat; tvalid stays high into the next call unless a gap is drawn
    task automatic send_point(int unsigned gc, int unsigned gr);
        int gap;
        gap = (idle_mode == IDLE_SEND) ? 51 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        while ($urandom_range(0, 99) < gap) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, gr[GRID_W-1:0], gc[GRID_W-1:0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // drop tvalid at once so the last beat is not offered a second time
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // corners, margin edges and centre of the current mesh
    task automatic directed_points();
        send_point(0, 0);
        send_point(1023, 1023);
        send_point(4, 4);
        send_point(cur_cols / 2, cur_rows / 2);
        send_point(10'h2AA, 10'h155);
    endtask

    task automatic random_points(int n);
        int unsigned gc, gr;
        repeat (n) begin
            if ($urandom_range(0, 3) != 0 && cur_cols > 0 && cur_rows > 0) begin
                gc = $urandom_range(0, (cur_cols > 1024 ? 1024 : cur_cols) - 1);
                gr = $urandom_range(0, (cur_rows > 1024 ? 1024 : cur_rows) - 1);
            end else begin
                gc = $urandom_range(0, 1023);
                gr = $urandom_range(0, 1023);
            end
            send_point(gc, gr);
        end
    endtask

    task automatic random_geometry();
        int unsigned c, r;
        c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 1024);
        r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 1024);
        set_geometry($urandom_range(1, 8192), $urandom_range(1, 8192), c, r,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(16, 20'hFFFFF),
                     $urandom_range(0, 21'h1FFFFF));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults
        directed_points();
        drain();
        // smallest legal settings, zero diagonal
        set_geometry(1, 1, 9, 9, 16, 0);
        directed_points();
        drain();
        // largest settings
        set_geometry(8192, 8192, 1024, 1024, 20'hFFFFF, 21'h1FFFFF);
        directed_points();
        drain();
        // masked widths, tiny mesh and f = 0: saturates
        set_geometry(21'h1FFFFF, 0, 5, 0, 0, 21'h1FFFFF);
        cfg_write(CFG_SPARE, 21'h12345);
        directed_points();
        send_point(4, 4);
        drain();
        // zero image size with f = 0: centre only
        set_geometry(0, 0, 104, 104, 0, 35248);
        directed_points();
        drain();

        // random phases across idle modes
        for (int ph = 0; ph < 8; ph++) begin
            idle_mode = t_idle_mode'(ph % 4);
            random_geometry();
            if (ph == 5) begin
                // keep offering points while the output is held off
                @(posedge i_clk);
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
            random_points(120);
            drain();
        end

        if (errors == 0)
            $display("tb_stereographic_mesh_warp: clean");
        else
            $display("tb_stereographic_mesh_warp: errors");
        $finish;
    end

endmodule
